>>> rtl/core/rgbycc_pkg.sv
// constants and helpers shared by the rgb to ycbcr 4:2:2 converter
`timescale 1ns / 1ps

package rgbycc_pkg;

    localparam int CFG_W = 13;
    localparam int LINE_WIDTH_RESET = 640;

    // q0.16 bt.601 full-range weights
    localparam logic [15:0] Y_R  = 16'd19595;
    localparam logic [15:0] Y_G  = 16'd38470;
    localparam logic [15:0] Y_B  = 16'd7471;
    localparam logic [15:0] CR_R = 16'd32768;
    localparam logic [15:0] CR_G = 16'd27440;
    localparam logic [15:0] CR_B = 16'd5328;
    localparam logic [15:0] CB_R = 16'd11056;
    localparam logic [15:0] CB_G = 16'd21712;
    localparam logic [15:0] CB_B = 16'd32768;

    localparam logic [23:0] CHROMA_BIAS = 24'd8388608;
    localparam logic [7:0]  CHROMA_MID  = 8'd128;

    // rounded [1,2,1]/4 filter
    function automatic logic [7:0] tap3(input logic [7:0] l, input logic [7:0] c,
                                        input logic [7:0] r);
        logic [9:0] sum;
        sum = 10'(l) + {1'b0, c, 1'b0} + 10'(r) + 10'd2;
        return sum[9:2];
    endfunction

endpackage

>>> rtl/core/rgb_to_ycbcr422_filtered.sv
// top level: rgb888 to ycbcr 4:2:2 with three-tap chroma filter
`timescale 1ns / 1ps

// Pixels enter on the s_axis channel in raster order, one beat per pixel
// (red, green, blue in tdata). Each pixel gives one beat on m_axis: tdata
// carries luma, and on every odd column (and the last column of an
// odd-width line) the filtered Cb/Cr of the even/odd pair, with tuser high.
// Otherwise the chroma bytes are zero. tlast marks the last pixel of a line.
// cfg_we/cfg_wdata set the line width (0 acts as 1, values above MAX_WIDTH
// act as MAX_WIDTH); write it only while the block is idle.
// Throughput is one pixel per clock while m_axis_tready stays high: a
// beat sits in the input register, goes through the color matrix and
// filter in one pass and lands in the output register, which drives
// m_axis_tvalid. The input register can still take a beat while a result
// waits in the output register; when the receiver stalls with both
// registers full, s_axis_tready drops. Reset clears both registers, the
// column counter and the filter history (neighbors at 128), and sets the
// line width to 640.

module rgb_to_ycbcr422_filtered
    import rgbycc_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [23:0]      s_axis_tdata,   // red, green, blue
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // luma, blue_diff, red_diff
    output logic [0:0]       m_axis_tuser,   // chroma_valid
    output logic             m_axis_tlast    // line_end
);

    localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int MW_W  = $clog2(MAX_WIDTH + 1);
    localparam int WW    = (MW_W > CFG_W) ? MW_W : CFG_W;
    localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);
    localparam logic [WW-1:0] RESET_W =
        (LINE_WIDTH_RESET > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(LINE_WIDTH_RESET);

    function automatic logic [WW-1:0] clamp_width(input logic [CFG_W-1:0] raw);
        logic [WW-1:0] ext;
        ext = WW'(raw);
        priority if (ext == '0) begin
            return WW'(1);
        end else if (ext > MAX_W) begin
            return MAX_W;
        end else begin
            return ext;
        end
    endfunction

    logic [WW-1:0]    width_reg;
    logic             in_valid_reg;
    logic [23:0]      in_data_reg;
    logic [COL_W-1:0] column_reg, column_next;
    logic [7:0]       left_cb_reg, left_cb_next, left_cr_reg, left_cr_next;
    logic [7:0]       center_cb_reg, center_cb_next, center_cr_reg, center_cr_next;
    logic             out_valid_reg;
    logic [23:0]      out_data_reg, out_data_next;
    logic             out_chroma_reg, out_chroma_next;
    logic             out_last_reg, out_last_next;

    logic        adv_out, fire, s_accept;
    logic [7:0]  red, green, blue, y, cb, cr, ocb, ocr;
    logic [23:0] y_sum;
    logic [24:0] cr_sum, cb_sum;
    logic        last;

    assign adv_out  = !out_valid_reg || m_axis_tready;
    assign fire     = in_valid_reg && adv_out;
    assign s_axis_tready = !in_valid_reg || adv_out;
    assign s_accept = s_axis_tvalid && s_axis_tready;

    assign red   = in_data_reg[7:0];
    assign green = in_data_reg[15:8];
    assign blue  = in_data_reg[23:16];

    always_comb begin
        y_sum  = 24'(red) * 24'(Y_R) + 24'(green) * 24'(Y_G) + 24'(blue) * 24'(Y_B);
        cr_sum = 25'(CHROMA_BIAS) + 25'(red) * 25'(CR_R)
               - 25'(green) * 25'(CR_G) - 25'(blue) * 25'(CR_B);
        cb_sum = 25'(CHROMA_BIAS) + 25'(blue) * 25'(CB_B)
               - 25'(red) * 25'(CB_R) - 25'(green) * 25'(CB_G);
        y  = y_sum[23:16];
        cr = cr_sum[23:16];
        cb = cb_sum[23:16];

        last = (WW'(column_reg) + WW'(1)) >= width_reg;

        center_cb_next  = center_cb_reg;
        center_cr_next  = center_cr_reg;
        left_cb_next    = left_cb_reg;
        left_cr_next    = left_cr_reg;
        ocb             = '0;
        ocr             = '0;
        out_chroma_next = 1'b0;

        if (!column_reg[0]) begin
            center_cb_next = cb;
            center_cr_next = cr;
            if (last) begin
                ocb = tap3(left_cb_reg, cb, CHROMA_MID);
                ocr = tap3(left_cr_reg, cr, CHROMA_MID);
                out_chroma_next = 1'b1;
            end
        end else begin
            ocb = tap3(left_cb_reg, center_cb_reg, cb);
            ocr = tap3(left_cr_reg, center_cr_reg, cr);
            out_chroma_next = 1'b1;
            left_cb_next = cb;
            left_cr_next = cr;
        end

        if (last) begin
            column_next  = '0;
            left_cb_next = CHROMA_MID;
            left_cr_next = CHROMA_MID;
        end else begin
            column_next = column_reg + COL_W'(1);
        end

        out_data_next = {ocr, ocb, y};
        out_last_next = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= RESET_W;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            column_reg    <= '0;
            left_cb_reg   <= CHROMA_MID;
            left_cr_reg   <= CHROMA_MID;
            center_cb_reg <= CHROMA_MID;
            center_cr_reg <= CHROMA_MID;
        end else begin
            if (cfg_we) begin
                width_reg <= clamp_width(cfg_wdata);
            end
            if (s_accept) begin
                in_valid_reg <= 1'b1;
                in_data_reg  <= s_axis_tdata;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (adv_out) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                column_reg     <= column_next;
                left_cb_reg    <= left_cb_next;
                left_cr_reg    <= left_cr_next;
                center_cb_reg  <= center_cb_next;
                center_cr_reg  <= center_cr_next;
                out_data_reg   <= out_data_next;
                out_chroma_reg <= out_chroma_next;
                out_last_reg   <= out_last_next;
            end
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_chroma_reg;
    assign m_axis_tlast    = out_last_reg;

    // chroma bytes are zero on beats without chroma
    a_chroma_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[23:8] == 16'd0))
        else $error("chroma bytes set without chroma flag");

    // chroma flag follows the column parity, or the line end, of the beat that moved out
    a_chroma_parity: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (m_axis_tuser[0] == ($past(column_reg[0]) || $past(last))))
        else $error("chroma flag does not match column");

    // a line end restarts the column and the left history
    a_line_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && last) |=> (column_reg == '0 && left_cb_reg == CHROMA_MID
                            && left_cr_reg == CHROMA_MID))
        else $error("line end did not restart filter state");

    // input side only stalls when both registers are full and the sink stalls
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a full pipeline");

endmodule

>>> tb/rgb_to_ycbcr422_filtered_tb.sv
// self-checking testbench for the rgb to ycbcr 4:2:2 converter with chroma filter
`timescale 1ns / 1ps

module rgb_to_ycbcr422_filtered_tb;
    import rgbycc_pkg::*;

    localparam int MAX_W       = 4096;
    localparam int HALF_PERIOD = 6;
    localparam int LONG_HOLD   = 50;
    localparam int RAND_PIXELS = 1500;
    localparam int TIMEOUT_CYC = 600000;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    typedef struct {
        logic [7:0] luma;
        logic [7:0] blue_diff;
        logic [7:0] red_diff;
        logic       chroma_valid;
        logic       line_end;
    } ycc_t;

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             cfg_we        = 1'b0;
    logic [CFG_W-1:0] cfg_wdata     = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [23:0]      s_axis_tdata  = '0;   // red, green, blue
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [23:0]      m_axis_tdata;         // luma, blue_diff, red_diff
    logic [0:0]       m_axis_tuser;         // chroma_valid
    logic             m_axis_tlast;

    rgb_to_ycbcr422_filtered #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #HALF_PERIOD aclk = ~aclk;

    rgb_t pixel_q[$];
    ycc_t pending_ycc[$];

    // converter state as the testbench sees it
    int line_w   = LINE_WIDTH_RESET;
    int col      = 0;
    int left_cb  = 128;
    int left_cr  = 128;
    int ctr_cb   = 128;
    int ctr_cr   = 128;

    bit calm      = 1'b0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int tx_wait   = 0;
    int rx_wait   = 0;
    int rx_next;

    int pixels_sent  = 0;
    int errors       = 0;
    int lines_seen   = 0;
    int chroma_seen  = 0;
    int settings     = 0;

    function automatic logic [7:0] smooth3(int l, int c, int r);
        int s;
        s = (l + 2 * c + r + 2) >> 2;
        return s[7:0];
    endfunction

    function automatic ycc_t convert_pixel(rgb_t px);
        int   r, g, b, yv, cbv, crv, eff;
        bit   at_end;
        ycc_t o;
        r = px.red;
        g = px.green;
        b = px.blue;
        eff = (line_w == 0) ? 1 : (line_w > MAX_W) ? MAX_W : line_w;
        yv  = (19595 * r + 38470 * g + 7471 * b) >>> 16;
        crv = (8388608 + 32768 * r - 27440 * g - 5328 * b) >>> 16;
        cbv = (8388608 - 11056 * r - 21712 * g + 32768 * b) >>> 16;
        at_end = (col + 1 >= eff);
        o.luma = yv[7:0];
        o.blue_diff = 8'd0;
        o.red_diff = 8'd0;
        o.chroma_valid = 1'b0;
        o.line_end = at_end;
        if (col % 2 == 0) begin
            ctr_cb = cbv;
            ctr_cr = crv;
            if (at_end) begin
                o.blue_diff = smooth3(left_cb, ctr_cb, 128);
                o.red_diff = smooth3(left_cr, ctr_cr, 128);
                o.chroma_valid = 1'b1;
            end
        end else begin
            o.blue_diff = smooth3(left_cb, ctr_cb, cbv);
            o.red_diff = smooth3(left_cr, ctr_cr, crv);
            o.chroma_valid = 1'b1;
            left_cb = cbv;
            left_cr = crv;
        end
        if (at_end) begin
            col = 0;
            left_cb = 128;
            left_cr = 128;
        end else begin
            col = col + 1;
        end
        return o;
    endfunction

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(0, 1) ? 8'hff : 8'h00;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic rgb_t rand_pixel();
        rgb_t p;
        p.red = rand_byte();
        p.green = rand_byte();
        p.blue = rand_byte();
        return p;
    endfunction

    // sender: one beat per queued pixel, random gap after each unless calm
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            tx_wait <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pending_ycc.push_back(convert_pixel(rgb_t'(s_axis_tdata)));
                pixels_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_wait > 0) begin
                    s_axis_tvalid <= 1'b0;
                    tx_wait <= tx_wait - 1;
                end else if (pixel_q.size() > 0) begin
                    s_axis_tdata <= pixel_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    tx_wait <= calm ? 0 : $urandom_range(0, 6);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_reqs != hold_seen) begin
            hold_left <= LONG_HOLD;
            hold_seen <= hold_reqs;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_wait <= 0;
        end else begin
            rx_next = rx_wait;
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_ycc.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected beat: tdata %h tuser %b tlast %b",
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    end
                end else begin
                    ycc_t e;
                    e = pending_ycc.pop_front();
                    if (m_axis_tdata[7:0] !== e.luma || m_axis_tdata[15:8] !== e.blue_diff ||
                        m_axis_tdata[23:16] !== e.red_diff ||
                        m_axis_tuser[0] !== e.chroma_valid || m_axis_tlast !== e.line_end) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch: exp y %h cb %h cr %h cv %b last %b",
                                     e.luma, e.blue_diff, e.red_diff, e.chroma_valid,
                                     e.line_end);
                            $display("          got y %h cb %h cr %h cv %b last %b",
                                     m_axis_tdata[7:0], m_axis_tdata[15:8],
                                     m_axis_tdata[23:16], m_axis_tuser[0], m_axis_tlast);
                        end
                    end
                end
                if (m_axis_tlast) lines_seen++;
                if (m_axis_tuser[0]) chroma_seen++;
                rx_next = calm ? 0 : $urandom_range(0, 6);
            end else if (rx_next > 0) begin
                rx_next = rx_next - 1;
            end
            rx_wait <= rx_next;
            m_axis_tready <= (rx_next == 0) && (hold_left == 0);
        end
    end

    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (pixel_q.size() != 0 || s_axis_tvalid || pending_ycc.size() != 0);
    endtask

    task automatic set_width(int v, bit quiet);
        wait_drained();
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= CFG_W'(v);
        calm <= quiet;
        line_w = v & ((1 << CFG_W) - 1);
        settings++;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        rgb_t p;
        p.red = r;
        p.green = g;
        p.blue = b;
        pixel_q.push_back(p);
    endtask

    initial begin
        int rand_count;
        int w;
        int n;
        int kind;
        rand_count = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset width, primaries and extremes, leaves the line mid-way at an odd column
        queue_pixel(8'h00, 8'h00, 8'h00);
        queue_pixel(8'hff, 8'hff, 8'hff);
        queue_pixel(8'hff, 8'h00, 8'h00);
        queue_pixel(8'h00, 8'hff, 8'h00);
        queue_pixel(8'h00, 8'h00, 8'hff);
        queue_pixel(8'hff, 8'hff, 8'h00);
        queue_pixel(8'h00, 8'hff, 8'hff);

        // zero width acts as one, shrink ends the line at an odd column
        set_width(0, 1'b0);
        queue_pixel(8'hff, 8'h00, 8'hff);
        queue_pixel(8'h80, 8'h80, 8'h80);
        queue_pixel(8'h00, 8'h00, 8'h00);

        // odd width: last column is even
        set_width(3, 1'b0);
        queue_pixel(8'hff, 8'h00, 8'h00);
        queue_pixel(8'h00, 8'h00, 8'hff);
        queue_pixel(8'hff, 8'hff, 8'hff);
        queue_pixel(8'h00, 8'hff, 8'h00);
        queue_pixel(8'h12, 8'h34, 8'h56);
        queue_pixel(8'hab, 8'hcd, 8'hef);

        // width shrunk while an even column is next
        set_width(5, 1'b0);
        queue_pixel(8'h00, 8'h00, 8'hff);
        queue_pixel(8'hff, 8'h00, 8'h00);
        set_width(2, 1'b0);
        queue_pixel(8'h00, 8'hff, 8'hff);
        queue_pixel(8'hff, 8'hff, 8'h00);
        queue_pixel(8'h7f, 8'h80, 8'h81);

        // receiver holds off while the sender keeps pushing
        set_width(16, 1'b1);
        hold_reqs <= hold_reqs + 1;
        repeat (60) pixel_q.push_back(rand_pixel());

        // oversized width clamps to the maximum, then the maximum itself
        set_width(8191, 1'b0);
        repeat (40) pixel_q.push_back(rand_pixel());
        set_width(4096, 1'b0);
        repeat (10) pixel_q.push_back(rand_pixel());
        set_width(3, 1'b0);
        repeat (4) pixel_q.push_back(rand_pixel());

        while (rand_count < RAND_PIXELS) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                w = $urandom_range(1, 16);
            end else if (kind == 6) begin
                w = $urandom_range(17, 80);
            end else if (kind == 7) begin
                w = $urandom_range(0, 2);
            end else if (kind == 8) begin
                w = $urandom_range(4096, 8191);
            end else begin
                w = $urandom_range(81, 4095);
            end
            if (w <= 80) begin
                n = $urandom_range(1, 3 * w + 3);
            end else begin
                n = $urandom_range(1, 40);
            end
            set_width(w, $urandom_range(0, 3) == 0);
            repeat (n) pixel_q.push_back(rand_pixel());
            rand_count += n;
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        $display("covered %0d pixels over %0d width settings: %0d line ends, %0d chroma beats",
                 pixels_sent, settings, lines_seen, chroma_seen);
        $display("%0d errors, %0d results still pending", errors, pending_ycc.size());
        if (errors == 0 && pending_ycc.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYC * 2 * HALF_PERIOD);
        $display("timeout with %0d results pending", pending_ycc.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> rgb_to_ycbcr422_filtered.f
rtl/core/rgbycc_pkg.sv
rtl/core/rgb_to_ycbcr422_filtered.sv
tb/rgb_to_ycbcr422_filtered_tb.sv
